// File: rtl/heading_pid_with_circular_mean_unit_defines.svh
`ifndef HEADING_PID_WITH_CIRCULAR_MEAN_UNIT_DEFINES_SVH
`define HEADING_PID_WITH_CIRCULAR_MEAN_UNIT_DEFINES_SVH

// Antecedent holds, consequent holds in the same cycle.
`define HPCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpcm: same-cycle check failed");

// Antecedent holds, consequent holds in the next cycle.
`define HPCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpcm: next-cycle check failed");

// Check that also spans reset itself.
`define HPCM_ASSERT_RESET(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hpcm: reset check failed");

`endif

// File: rtl/hpcm_pkg.sv
`timescale 1ns / 1ps
package hpcm_pkg;
    localparam int WINDOW_DEF = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_KP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VMAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THR = 3'd4;

    localparam logic KIND_HEADING = 1'b0;
    localparam logic KIND_CMD = 1'b1;
    localparam logic REQ_YAW = 1'b0;

    localparam int CW = 34;   // CORDIC x/y datapath
    localparam int ZW = 21;   // CORDIC angle, Q16
    localparam int SUM_W = 20;
    localparam int ACC_W = 52;
    localparam int STEPS = 16;

    localparam logic signed [17:0] PI_Q13 = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic signed [ZW-1:0] PI_Q16 = 21'sd205887;
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 21'sd102944;
    localparam logic signed [CW-1:0] GAIN_Q29 = 34'sd326016435;
    localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            4'd0: v = 21'sd51472;
            4'd1: v = 21'sd30386;
            4'd2: v = 21'sd16055;
            4'd3: v = 21'sd8150;
            4'd4: v = 21'sd4091;
            4'd5: v = 21'sd2047;
            4'd6: v = 21'sd1024;
            4'd7: v = 21'sd512;
            4'd8: v = 21'sd256;
            4'd9: v = 21'sd128;
            4'd10: v = 21'sd64;
            4'd11: v = 21'sd32;
            4'd12: v = 21'sd16;
            4'd13: v = 21'sd8;
            4'd14: v = 21'sd4;
            default: v = 21'sd2;
        endcase
        return v;
    endfunction

    // Bring a difference of angles into (-pi, pi]; one correction suffices.
    function automatic logic signed [15:0] wrap_q13(input logic signed [17:0] a);
        logic signed [17:0] r;
        if (a > PI_Q13) r = a - TWO_PI_Q13;
        else if (a <= -PI_Q13) r = a + TWO_PI_Q13;
        else r = a;
        return r[15:0];
    endfunction

    // Round half up by 15 bits and clamp to +-1.0 in Q1.14.
    function automatic logic signed [15:0] round_unit(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        logic signed [15:0] r;
        t = (v + CW'(16384)) >>> 15;
        if (t > CW'(UNIT_Q14)) r = UNIT_Q14;
        else if (t < -CW'(UNIT_Q14)) r = -UNIT_Q14;
        else r = t[15:0];
        return r;
    endfunction
endpackage

// File: rtl/hpcm_in_if.sv
`timescale 1ns / 1ps
interface hpcm_in_if;
    logic valid;
    logic ready;
    logic req_type;
    logic signed [15:0] angle_value;
    modport source (output valid, req_type, angle_value, input ready);
    modport sink (input valid, req_type, angle_value, output ready);
endinterface

// File: rtl/hpcm_out_if.sv
`timescale 1ns / 1ps
interface hpcm_out_if;
    logic valid;
    logic ready;
    logic result_kind;
    logic signed [15:0] result_value;
    logic last;
    modport source (output valid, result_kind, result_value, last, input ready);
    modport sink (input valid, result_kind, result_value, last, output ready);
endinterface

// File: rtl/heading_pid_with_circular_mean_unit.sv
`timescale 1ns / 1ps
// A target word either gives its stop word or arms control and is ready again.
// A yaw word gives its heading report after 16 rotation and 16 vectoring steps
// on the one shared CORDIC unit; vectoring is skipped when both sums are zero.
// With control active, the PID steps on the one shared multiplier (error,
// products, accumulate, velocity limit) come first, then command and report.
// Throughput: one word at a time, ready only while idle; a held output word
// stalls the sequencer. Reset (sync, active low) clears control, sums,
// counters and the gains to defaults; the sample ring keeps stale data.
module heading_pid_with_circular_mean_unit
    import hpcm_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hpcm_in_if.sink               i_in,
    hpcm_out_if.source            o_out
);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_TGT    = 15'b000000000000010,
        S_FOLD   = 15'b000000000000100,
        S_ROT    = 15'b000000000001000,
        S_RING   = 15'b000000000010000,
        S_VLOAD  = 15'b000000000100000,
        S_VEC    = 15'b000000001000000,
        S_HEAD   = 15'b000000010000000,
        S_ERR    = 15'b000000100000000,
        S_MUL    = 15'b000001000000000,
        S_MADD   = 15'b000010000000000,
        S_VEL    = 15'b000100000000000,
        S_E_CMD  = 15'b001000000000000,
        S_E_ZERO = 15'b010000000000000,
        S_E_HEAD = 15'b100000000000000
    } t_state;

    // Configuration
    logic [15:0] r_kp, r_ki, r_kd;
    logic [14:0] r_vmax, r_thr;

    // Control and datapath state
    t_state r_state;
    logic r_tzero;                  // target answered by a single stop word
    logic signed [15:0] r_ang;
    logic [3:0] r_cnt;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic r_flip;
    logic signed [15:0] r_sin_ring [WINDOW];
    logic signed [15:0] r_cos_ring [WINDOW];
    logic signed [SUM_W-1:0] r_ssum, r_csum;
    logic [FILL_W-1:0] r_fill;
    logic [SLOT_W-1:0] r_slot;
    logic r_active;
    logic signed [15:0] r_target, r_heading, r_prior, r_err, r_vel;
    logic signed [31:0] r_integ;
    logic signed [ACC_W-1:0] r_acc, r_prod;

    // Output register
    logic r_ovalid, r_okind, r_olast;
    logic signed [15:0] r_oval;

    logic out_free;
    logic out_load;
    assign out_free = !r_ovalid || o_out.ready;
    // Load the output register from one of the emit states.
    assign out_load = out_free && (r_state == S_E_CMD || r_state == S_E_ZERO ||
                                   r_state == S_E_HEAD);

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.result_kind = r_okind;
    assign o_out.result_value = r_oval;
    assign o_out.last = r_olast;

    // Shared CORDIC step: rotation drives z to 0, vectoring drives y to 0.
    logic signed [CW-1:0] sx, sy;
    logic signed [ZW-1:0] at;
    logic rot_pos, vec_pos;
    assign sx = r_x >>> r_cnt;
    assign sy = r_y >>> r_cnt;
    assign at = atan_q16(r_cnt);
    assign rot_pos = !r_z[ZW-1];
    assign vec_pos = !r_y[CW-1] && (r_y != '0);

    // Fold the wrapped yaw angle into [-pi/2, pi/2] at Q16.
    logic signed [15:0] w_ang;
    logic signed [ZW-1:0] z0;
    assign w_ang = wrap_q13(18'(r_ang));
    assign z0 = ZW'(w_ang) <<< 3;

    // Ring update.
    logic signed [15:0] s_new, c_new;
    logic full;
    assign s_new = round_unit(r_flip ? -r_y : r_y);
    assign c_new = round_unit(r_flip ? -r_x : r_x);
    assign full = (r_fill >= FILL_FULL);

    // Heading rounding.
    logic signed [ZW-1:0] z_rnd;
    assign z_rnd = (r_z + ZW'(4)) >>> 3;

    // Errors against target.
    logic signed [15:0] tgt_w, tgt_err, pid_err;
    assign tgt_w = wrap_q13(18'(r_ang));
    assign tgt_err = wrap_q13(18'(tgt_w) - 18'(r_heading));
    assign pid_err = wrap_q13(18'(r_target) - 18'(r_heading));

    function automatic logic below_thr(input logic signed [15:0] e,
                                       input logic [14:0] thr);
        logic [15:0] m;
        m = e[15] ? 16'(-e) : 16'(e);
        return m < {1'b0, thr};
    endfunction

    logic signed [32:0] integ_sum;
    assign integ_sum = 33'(r_integ) + 33'(pid_err);

    // Shared multiplier: gain times err, integral, then err difference.
    logic signed [16:0] m_gain;
    logic signed [32:0] m_opnd;
    logic signed [49:0] m_prod;
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: begin
                m_gain = 17'({1'b0, r_kp});
                m_opnd = 33'(r_err);
            end
            2'd1: begin
                m_gain = 17'({1'b0, r_ki});
                m_opnd = 33'(r_integ);
            end
            default: begin
                m_gain = 17'({1'b0, r_kd});
                m_opnd = 33'(r_err) - 33'(r_prior);
            end
        endcase
    end
    assign m_prod = m_gain * m_opnd;

    logic signed [ACC_W-1:0] vel_raw;
    logic signed [ACC_W-1:0] vlim;
    assign vel_raw = (r_acc + ACC_W'(2048)) >>> 12;
    assign vlim = ACC_W'({1'b0, r_vmax});

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= 16'd2048;
            r_ki <= 16'd41;
            r_kd <= 16'd410;
            r_vmax <= 15'd819;
            r_thr <= 15'd410;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KP: r_kp <= i_cfg_data;
                REG_KI: r_ki <= i_cfg_data;
                REG_KD: r_kd <= i_cfg_data;
                REG_VMAX: r_vmax <= i_cfg_data[14:0];
                REG_THR: r_thr <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Ring storage: written once per yaw word, no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RING) begin
            r_sin_ring[r_slot] <= s_new;
            r_cos_ring[r_slot] <= c_new;
        end
    end

    // Payload registers without reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_ang <= i_in.angle_value;
        end
        unique case (r_state)
            S_FOLD: begin
                r_x <= GAIN_Q29;
                r_y <= '0;
                if (z0 > HALF_PI_Q16) begin
                    r_z <= z0 - PI_Q16;
                    r_flip <= 1'b1;
                end else if (z0 < -HALF_PI_Q16) begin
                    r_z <= z0 + PI_Q16;
                    r_flip <= 1'b1;
                end else begin
                    r_z <= z0;
                    r_flip <= 1'b0;
                end
            end
            S_ROT: begin
                if (rot_pos) begin
                    r_x <= r_x - sy;
                    r_y <= r_y + sx;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + sy;
                    r_y <= r_y - sx;
                    r_z <= r_z + at;
                end
            end
            S_VLOAD: begin
                // Left half plane: negate the vector and start from +-pi.
                if (r_csum < 0) begin
                    r_x <= -(CW'(r_csum) <<< 10);
                    r_y <= -(CW'(r_ssum) <<< 10);
                    r_z <= (r_ssum >= 0) ? PI_Q16 : -PI_Q16;
                end else begin
                    r_x <= CW'(r_csum) <<< 10;
                    r_y <= CW'(r_ssum) <<< 10;
                    r_z <= '0;
                end
            end
            S_VEC: begin
                if (vec_pos) begin
                    r_x <= r_x + sy;
                    r_y <= r_y - sx;
                    r_z <= r_z + at;
                end else begin
                    r_x <= r_x - sy;
                    r_y <= r_y + sx;
                    r_z <= r_z - at;
                end
            end
            S_ERR: begin
                r_err <= pid_err;
                r_acc <= '0;
            end
            S_MUL: begin
                r_prod <= ACC_W'(m_prod);
                if (r_cnt != 4'd0) r_acc <= r_acc + r_prod;
            end
            S_MADD: r_acc <= r_acc + r_prod;
            S_VEL: begin
                if (vel_raw > vlim) r_vel <= vlim[15:0];
                else if (vel_raw < -vlim) r_vel <= 16'(-vlim);
                else r_vel <= vel_raw[15:0];
            end
            default: ;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tzero <= 1'b0;
            r_cnt <= '0;
            r_ssum <= '0;
            r_csum <= '0;
            r_fill <= '0;
            r_slot <= '0;
            r_active <= 1'b0;
            r_target <= '0;
            r_heading <= '0;
            r_prior <= '0;
            r_integ <= '0;
            r_ovalid <= 1'b0;
            r_okind <= KIND_HEADING;
            r_oval <= '0;
            r_olast <= 1'b0;
        end else begin
            // Hold the output word until taken; load a new one when free.
            if (out_load) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid)
                        r_state <= (i_in.req_type == REQ_YAW) ? S_FOLD : S_TGT;
                end
                S_TGT: begin
                    r_target <= tgt_w;
                    if (below_thr(tgt_err, r_thr)) begin
                        r_tzero <= 1'b1;
                        r_state <= S_E_ZERO;
                    end else begin
                        r_active <= 1'b1;
                        r_integ <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_FOLD: begin
                    r_cnt <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(STEPS - 1)) r_state <= S_RING;
                end
                S_RING: begin
                    // Drop the oldest entry once the window is full.
                    r_ssum <= r_ssum + SUM_W'(s_new)
                              - (full ? SUM_W'(r_sin_ring[r_slot]) : SUM_W'(0));
                    r_csum <= r_csum + SUM_W'(c_new)
                              - (full ? SUM_W'(r_cos_ring[r_slot]) : SUM_W'(0));
                    if (!full) r_fill <= r_fill + FILL_W'(1);
                    r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + SLOT_W'(1);
                    r_state <= S_VLOAD;
                end
                S_VLOAD: begin
                    r_cnt <= '0;
                    if (r_ssum == '0 && r_csum == '0) begin
                        r_heading <= '0;
                        r_state <= r_active ? S_ERR : S_E_HEAD;
                    end else begin
                        r_state <= S_VEC;
                    end
                end
                S_VEC: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(STEPS - 1)) r_state <= S_HEAD;
                end
                S_HEAD: begin
                    if (z_rnd > ZW'(PI_Q13)) r_heading <= PI_Q13[15:0];
                    else if (z_rnd < -ZW'(PI_Q13)) r_heading <= 16'(-PI_Q13);
                    else r_heading <= z_rnd[15:0];
                    r_state <= r_active ? S_ERR : S_E_HEAD;
                end
                S_ERR: begin
                    // Saturate the integral at the 32-bit limits.
                    if (integ_sum > 33'sh0_7FFF_FFFF) r_integ <= 32'sh7FFF_FFFF;
                    else if (integ_sum < -33'sh0_8000_0000) r_integ <= 32'sh8000_0000;
                    else r_integ <= integ_sum[31:0];
                    r_cnt <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd2) r_state <= S_MADD;
                end
                S_MADD: r_state <= S_VEL;
                S_VEL: begin
                    r_prior <= r_err;
                    r_state <= S_E_CMD;
                end
                S_E_CMD: begin
                    if (out_free) begin
                        r_okind <= KIND_CMD;
                        r_oval <= r_vel;
                        r_olast <= 1'b0;
                        r_state <= below_thr(r_err, r_thr) ? S_E_ZERO : S_E_HEAD;
                    end
                end
                S_E_ZERO: begin
                    if (out_free) begin
                        r_okind <= KIND_CMD;
                        r_oval <= '0;
                        r_olast <= r_tzero;
                        r_tzero <= 1'b0;
                        if (!r_tzero) begin
                            r_active <= 1'b0;
                            r_integ <= '0;
                        end
                        r_state <= r_tzero ? S_IDLE : S_E_HEAD;
                    end
                end
                S_E_HEAD: begin
                    if (out_free) begin
                        r_okind <= KIND_HEADING;
                        r_oval <= r_heading;
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/hpcm_checker.sv
`timescale 1ns / 1ps
`include "heading_pid_with_circular_mean_unit_defines.svh"
module hpcm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_kind,
    input logic i_out_last
);
    // One word at a time: no second accept right after one.
    `HPCM_ASSERT_NEXT(a_one_word, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // Only velocity commands come before the final word of an input.
    `HPCM_ASSERT_NOW(a_mid_is_cmd, i_clk, i_rst_n, i_out_valid && !i_out_last, i_out_kind)
    // Reset empties the output.
    `HPCM_ASSERT_RESET(a_reset_clear, i_clk, !i_rst_n, !i_out_valid)
    // Held word stays until taken.
    `HPCM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
endmodule

bind heading_pid_with_circular_mean_unit hpcm_checker u_hpcm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.result_kind),
    .i_out_last  (o_out.last)
);

// File: tb/heading_pid_with_circular_mean_unit_test.sv
`timescale 1ns / 1ps
module heading_pid_with_circular_mean_unit_test;
    import hpcm_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [15:0] value;
        logic        last;
    } t_result_word;

    // One row of the directed stimulus. has_result marks rows whose first
    // result word can be read off directly; the predictor checks the rest.
    typedef struct {
        logic        req;
        logic [15:0] angle;
        bit          has_result;
        logic        exp_kind;
        logic [15:0] exp_value;
    } t_stim_row;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int N_RANDOM       = 500;
    localparam int PI_VAL         = 25736;
    localparam int TWO_PI_VAL     = 51472;
    localparam int PI_Z           = 205887;
    localparam int HALF_PI_Z      = 102944;
    localparam logic REQ_TARGET   = 1'b1;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    hpcm_in_if  in_ch ();
    hpcm_out_if out_ch ();

    heading_pid_with_circular_mean_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // Predictor copy of the block state and registers.
    longint sin_ring [WINDOW_DEF];
    longint cos_ring [WINDOW_DEF];
    longint sin_acc, cos_acc;
    int     fill_cnt, slot_ptr;
    bit     steering;
    longint goal_heading, last_err, err_accum, mean_heading;
    longint kp_reg, ki_reg, kd_reg, vmax_reg, thr_reg;

    t_result_word expected_words[$];
    int  fail_count;
    int  idle_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  step_base;
    bit  hold_off;

    int atan_tab [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint wrap_pi(longint a);
        while (a > PI_VAL) a -= TWO_PI_VAL;
        while (a <= -PI_VAL) a += TWO_PI_VAL;
        return a;
    endfunction

    function automatic longint to_unit(longint v);
        longint r;
        r = fshift(v + 16384, 15);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    // Rotation-mode CORDIC: sine and cosine in Q1.14 of a Q2.13 angle.
    task automatic rotate_angle(input longint ang, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit flip;
        z = wrap_pi(ang) * 8;
        x = 326016435;
        y = 0;
        flip = 0;
        if (z > HALF_PI_Z) begin
            z -= PI_Z;
            flip = 1;
        end else if (z < -HALF_PI_Z) begin
            z += PI_Z;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = to_unit(y);
        c = to_unit(x);
    endtask

    // Vectoring-mode CORDIC: heading of the summed unit vectors.
    function automatic longint vector_heading(longint ys, longint xs);
        longint x, y, z, dx, dy, r;
        if (xs == 0 && ys == 0) return 0;
        x = xs * 1024;
        y = ys * 1024;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Z : -PI_Z;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        r = fshift(z + 4, 3);
        if (r > PI_VAL) r = PI_VAL;
        if (r < -PI_VAL) r = -PI_VAL;
        return r;
    endfunction

    function automatic longint abs_l(longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic push_word(logic kind, longint value, logic last);
        t_result_word w;
        w.kind  = kind;
        w.value = value[15:0];
        w.last  = last;
        expected_words.insert(expected_words.size(), w);
    endtask

    task automatic predictor_reset();
        sin_acc = 0; cos_acc = 0; fill_cnt = 0; slot_ptr = 0;
        steering = 0; goal_heading = 0; last_err = 0; err_accum = 0;
        mean_heading = 0;
        kp_reg = 2048; ki_reg = 41; kd_reg = 410; vmax_reg = 819; thr_reg = 410;
    endtask

    // Work out every result word that one accepted input word causes.
    task automatic predict_heading_step(logic req, logic [15:0] raw);
        longint ang, err, s, c, acc, vel;
        ang = longint'($signed(raw));
        if (req == REQ_TARGET) begin
            goal_heading = wrap_pi(ang);
            err = wrap_pi(goal_heading - mean_heading);
            if (abs_l(err) < thr_reg) begin
                push_word(KIND_CMD, 0, 1'b1);
            end else begin
                steering = 1;
                err_accum = 0;
            end
            return;
        end
        rotate_angle(ang, s, c);
        if (fill_cnt >= WINDOW_DEF) begin
            sin_acc -= sin_ring[slot_ptr];
            cos_acc -= cos_ring[slot_ptr];
        end else begin
            fill_cnt++;
        end
        sin_ring[slot_ptr] = s;
        cos_ring[slot_ptr] = c;
        sin_acc += s;
        cos_acc += c;
        slot_ptr = (slot_ptr + 1) % WINDOW_DEF;
        mean_heading = vector_heading(sin_acc, cos_acc);
        if (steering) begin
            err = wrap_pi(goal_heading - mean_heading);
            err_accum += err;
            if (err_accum > 64'sd2147483647) err_accum = 64'sd2147483647;
            if (err_accum < -64'sd2147483648) err_accum = -64'sd2147483648;
            acc = kp_reg * err + ki_reg * err_accum + kd_reg * (err - last_err);
            vel = fshift(acc + 2048, 12);
            if (vel > vmax_reg) vel = vmax_reg;
            if (vel < -vmax_reg) vel = -vmax_reg;
            push_word(KIND_CMD, vel, 1'b0);
            last_err = err;
            if (abs_l(err) < thr_reg) begin
                push_word(KIND_CMD, 0, 1'b0);
                steering = 0;
                err_accum = 0;
            end
        end
        push_word(KIND_HEADING, mean_heading, 1'b1);
    endtask

    // Write one register between phases, with the block idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_KP:   kp_reg   = data;
            REG_KI:   ki_reg   = data;
            REG_KD:   kd_reg   = data;
            REG_VMAX: vmax_reg = data[14:0];
            REG_THR:  thr_reg  = data[14:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                             logic [15:0] vmax, logic [15:0] thr);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_VMAX, vmax);
        write_reg(REG_THR, thr);
    endtask

    // Offer one word, idling first at the current rate, and predict on accept.
    // Valid stays high after the accept until the next word or an idle cycle.
    task automatic send_word(logic req, logic [15:0] angle);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.req_type    <= req;
        in_ch.angle_value <= angle;
        do @(posedge i_clk); while (!in_ch.ready);
        step_base = expected_words.size();
        predict_heading_step(req, angle);
    endtask

    // Drop valid, wait for every expected word, then let the block settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] random_angle();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(PI_VAL * 2) - PI_VAL);
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: stall at the phase rate, or hold off entirely on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_result_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: kind %0d value %0d last %0d",
                       out_ch.result_kind, out_ch.result_value, out_ch.last);
                fail_count++;
            end else begin
                want = expected_words[0];
                expected_words.delete(0);
                if (out_ch.result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, actual %0d",
                           want.kind, out_ch.result_kind);
                    fail_count++;
                end
                if (out_ch.result_value !== want.value) begin
                    $error("result_value: expected %0d, actual %0d",
                           $signed(want.value), out_ch.result_value);
                    fail_count++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, out_ch.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("heading_pid_with_circular_mean_unit regression: fail");
            $finish;
        end
    end

    // Pressure: long receiver hold-off, counted here, while the sender keeps going.
    task automatic long_hold();
        hold_off = 1;
        repeat (400) @(posedge i_clk);
        hold_off = 0;
    endtask

    t_stim_row directed[$];

    task automatic add_row(logic req, logic [15:0] angle, bit has, logic k, logic [15:0] v);
        t_stim_row r;
        r.req = req; r.angle = angle; r.has_result = has;
        r.exp_kind = k; r.exp_value = v;
        directed.insert(directed.size(), r);
    endtask

    initial begin
        int phase_len;
        t_result_word head;
        fail_count = 0;
        idle_count = 0;
        step_base = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.req_type = REQ_YAW;
        in_ch.angle_value = '0;
        predictor_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: a target equal to the reset heading is reached on
        // arrival; after one yaw of zero a nearby target is reached too;
        // extremes follow.
        add_row(REQ_TARGET, 16'd0,      1, KIND_CMD, 16'd0);
        add_row(REQ_YAW,    16'd0,      0, 0, 0);
        add_row(REQ_TARGET, 16'd100,    1, KIND_CMD, 16'd0);
        add_row(REQ_TARGET, 16'h7FFF,   0, 0, 0);
        add_row(REQ_YAW,    16'h8000,   0, 0, 0);
        add_row(REQ_YAW,    16'h7FFF,   0, 0, 0);
        add_row(REQ_YAW,    16'd25736,  0, 0, 0);
        add_row(REQ_YAW,    -16'sd25736, 0, 0, 0);
        add_row(REQ_TARGET, 16'h8000,   0, 0, 0);
        add_row(REQ_YAW,    16'd12868,  0, 0, 0);
        add_row(REQ_YAW,    -16'sd12868, 0, 0, 0);
        for (int i = 0; i < 12; i++) add_row(REQ_YAW, 16'(i * 4000), 0, 0, 0);
        add_row(REQ_TARGET, 16'hFFFF,   0, 0, 0);

        foreach (directed[i]) begin
            send_word(directed[i].req, directed[i].angle);
            if (directed[i].has_result) begin
                head = expected_words[step_base];
                if (head.kind !== directed[i].exp_kind) begin
                    $error("result_kind: expected %0d, actual %0d",
                           directed[i].exp_kind, head.kind);
                    fail_count++;
                end
                if (head.value !== directed[i].exp_value) begin
                    $error("result_value: expected %0d, actual %0d",
                           $signed(directed[i].exp_value), $signed(head.value));
                    fail_count++;
                end
            end
        end
        drain();

        // Random phases: each with its own register setting and idling mix.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'd0);
                   send_idle_pct = 0;  recv_stall_pct = 0; end
                1: begin write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'h7FFF);
                   send_idle_pct = 84; recv_stall_pct = 0; end
                2: begin write_all(16'd4096, 16'd2000, 16'd800, 16'd3000, 16'd200);
                   send_idle_pct = 0;  recv_stall_pct = 84; end
                3: begin write_all(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom), 16'($urandom_range(1500)));
                   send_idle_pct = 38; recv_stall_pct = 38; end
                4: begin write_all(16'd2048, 16'hFFFF, 16'd0, 16'h7FFF, 16'd50);
                   send_idle_pct = 0;  recv_stall_pct = 0; end
                default: begin write_all(16'd2048, 16'd41, 16'd410, 16'd819, 16'd410);
                   send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            phase_len = N_RANDOM / 6;
            fork
                if (ph == 2) long_hold();
                begin
                    // Mostly a target followed by a run of yaw words near it.
                    int n;
                    logic [15:0] goal;
                    n = 0;
                    while (n < phase_len) begin
                        goal = random_angle();
                        send_word(REQ_TARGET, goal);
                        n++;
                        for (int k = $urandom_range(15); k > 0 && n < phase_len; k--) begin
                            if ($urandom_range(3) == 0)
                                send_word(REQ_YAW, random_angle());
                            else
                                send_word(REQ_YAW, 16'(goal + $urandom_range(2000) - 1000));
                            n++;
                        end
                    end
                end
            join
            drain();
        end

        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("heading_pid_with_circular_mean_unit regression: pass");
        end else begin
            $display("heading_pid_with_circular_mean_unit regression: fail");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/hpcm_pkg.sv
rtl/hpcm_in_if.sv
rtl/hpcm_out_if.sv
rtl/heading_pid_with_circular_mean_unit.sv
rtl/hpcm_checker.sv
tb/heading_pid_with_circular_mean_unit_test.sv
